// File: rtl/bcdtod_pkg.sv
// Shared types, constants and helpers for the BCD calendar to time-of-day converter.
`timescale 1ns / 1ps

package bcdtod_pkg;

  localparam int unsigned BaseYear    = 1900;
  localparam int unsigned EndYear     = 2042;
  localparam int unsigned EndMonth    = 9;
  localparam int unsigned EndDay      = 17;
  localparam int unsigned EndHour     = 23;
  localparam int unsigned EndMinute   = 53;
  localparam int unsigned EndSecond   = 47;
  localparam int unsigned DaysPerYear = 365;
  localparam int unsigned ScaleSec    = 15625;
  localparam int unsigned FinalShift  = 18;
  localparam int unsigned TodWidth    = 64;
  localparam int unsigned SumWidth    = TodWidth - FinalShift;
  localparam logic signed [31:0] TicksPerDay = 32'sd1350000000;  // 86400 * 15625

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusEarly = 2'd1,
    StatusLate  = 2'd2
  } status_e;

  // Decoded calendar fields.
  typedef struct packed {
    logic [14:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } dec_t;

  // Terms of the day count, checked range.
  typedef struct packed {
    status_e     status;
    logic [7:0]  yr_off;
    logic [5:0]  quad;
    logic        leap_add;
    logic [7:0]  day;
    logic [8:0]  dbm;
    logic [19:0] since_mid;
  } terms_t;

  // Day count and scaled seconds of the day.
  typedef struct packed {
    status_e     status;
    logic [17:0] days;
    logic [33:0] sec_ticks;
  } days_t;

  // Partial tick counts ready to sum.
  typedef struct packed {
    status_e             status;
    logic [SumWidth-1:0] day_ticks;
    logic [33:0]         sec_ticks;
  } ticks_t;

  function automatic logic [7:0] bcd_value(input logic [7:0] b);
    return {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
  endfunction

  function automatic logic [8:0] days_before_month(input logic [7:0] month);
    logic [8:0] d;
    d = 9'd0;
    unique case (month)
      8'd1:    d = 9'd0;
      8'd2:    d = 9'd31;
      8'd3:    d = 9'd59;
      8'd4:    d = 9'd90;
      8'd5:    d = 9'd120;
      8'd6:    d = 9'd151;
      8'd7:    d = 9'd181;
      8'd8:    d = 9'd212;
      8'd9:    d = 9'd243;
      8'd10:   d = 9'd273;
      8'd11:   d = 9'd304;
      8'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/bcdtod_decode.sv
// Two pipeline stages: BCD decode, then range check and day-count terms.
`timescale 1ns / 1ps

module bcdtod_decode import bcdtod_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  logic [7:0]   century_bcd_i,
  input  logic [7:0]   year_in_century_bcd_i,
  input  logic [7:0]   month_bcd_i,
  input  logic [7:0]   day_bcd_i,
  input  logic [7:0]   hour_bcd_i,
  input  logic [7:0]   minute_bcd_i,
  input  logic [7:0]   second_bcd_i,
  output logic         valid_o,
  input  logic         ready_i,
  output terms_t       terms_o
);

  logic   vld_a_q, vld_b_q;
  logic   rdy_a, rdy_b;
  dec_t   dec_d, dec_q;
  terms_t terms_d, terms_q;
  logic [14:0] cent;
  logic [14:0] yr_full;
  logic [7:0]  yr_m1;
  logic        late;

  assign rdy_b   = !vld_b_q || ready_i;
  assign rdy_a   = !vld_a_q || rdy_b;
  assign ready_o = rdy_a;
  assign valid_o = vld_b_q;
  assign terms_o = terms_q;

  always_comb begin
    cent          = 15'(bcd_value(century_bcd_i));
    dec_d.year    = (cent << 6) + (cent << 5) + (cent << 2)
                  + 15'(bcd_value(year_in_century_bcd_i));
    dec_d.month   = bcd_value(month_bcd_i);
    dec_d.day     = bcd_value(day_bcd_i);
    dec_d.hour    = bcd_value(hour_bcd_i);
    dec_d.minute  = bcd_value(minute_bcd_i);
    dec_d.second  = bcd_value(second_bcd_i);
  end

  always_comb begin
    late = (dec_q.year >= 15'(EndYear)) &&
           ((dec_q.year > 15'(EndYear)) ||
            (dec_q.month > 8'(EndMonth)) ||
            (dec_q.month == 8'(EndMonth) && dec_q.day > 8'(EndDay)) ||
            (dec_q.month == 8'(EndMonth) && dec_q.day == 8'(EndDay) &&
             dec_q.hour == 8'(EndHour) &&
             ((dec_q.minute > 8'(EndMinute)) ||
              (dec_q.minute == 8'(EndMinute) && dec_q.second > 8'(EndSecond)))));
    if (dec_q.year < 15'(BaseYear)) begin
      terms_d.status = StatusEarly;
    end else if (late) begin
      terms_d.status = StatusLate;
    end else begin
      terms_d.status = StatusOk;
    end
    yr_full          = dec_q.year - 15'(BaseYear);
    terms_d.yr_off   = yr_full[7:0];
    yr_m1            = yr_full[7:0] - 8'd1;
    // no leap days have passed before the first year after the base
    terms_d.quad     = (yr_full[7:0] != 8'd0) ? yr_m1[7:2] : 6'd0;
    terms_d.leap_add = (yr_full[7:0] != 8'd0) && (yr_full[1:0] == 2'b00)
                     && (dec_q.month > 8'd2);
    terms_d.day      = dec_q.day;
    terms_d.dbm      = days_before_month(dec_q.month);
    terms_d.since_mid = 20'(dec_q.second) + 20'(dec_q.minute) * 20'd60
                      + 20'(dec_q.hour) * 20'd3600;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (rdy_a) vld_a_q <= valid_i;
      if (rdy_b) vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) dec_q <= dec_d;
    if (rdy_b && vld_a_q) terms_q <= terms_d;
  end

endmodule

// File: rtl/bcdtod_days.sv
// Pipeline stage that forms the day count and scales the seconds of the day.
`timescale 1ns / 1ps

module bcdtod_days import bcdtod_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   ready_o,
  input  terms_t terms_i,
  output logic   valid_o,
  input  logic   ready_i,
  output days_t  days_o
);

  logic  vld_q;
  days_t days_d, days_q;

  assign ready_o = !vld_q || ready_i;
  assign valid_o = vld_q;
  assign days_o  = days_q;

  always_comb begin
    days_d.status    = terms_i.status;
    // day zero of the base year wraps to minus one here
    days_d.days      = 18'(terms_i.yr_off) * 18'(DaysPerYear) + 18'(terms_i.quad)
                     + 18'(terms_i.day) + 18'(terms_i.dbm) + 18'(terms_i.leap_add)
                     - 18'd1;
    days_d.sec_ticks = 34'(terms_i.since_mid) * 34'(ScaleSec);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) days_q <= days_d;
  end

endmodule

// File: rtl/bcdtod_scale.sv
// Two pipeline stages: day ticks multiply, then final sum, shift and output register.
`timescale 1ns / 1ps

module bcdtod_scale import bcdtod_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  days_t               days_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [TodWidth-1:0] tod_o,
  output status_e             status_o
);

  logic                vld_a_q, vld_b_q;
  logic                rdy_a, rdy_b;
  ticks_t              ticks_d, ticks_q;
  logic signed [17:0]  days_s;
  logic signed [48:0]  prod;
  logic [SumWidth-1:0] sum;
  logic [TodWidth-1:0] tod_d, tod_q;
  status_e             status_q;

  assign rdy_b    = !vld_b_q || ready_i;
  assign rdy_a    = !vld_a_q || rdy_b;
  assign ready_o  = rdy_a;
  assign valid_o  = vld_b_q;
  assign tod_o    = tod_q;
  assign status_o = status_q;

  always_comb begin
    days_s            = $signed(days_i.days);
    prod              = days_s * TicksPerDay;
    ticks_d.status    = days_i.status;
    // bits above the shifted width fall off the count anyway
    ticks_d.day_ticks = prod[SumWidth-1:0];
    ticks_d.sec_ticks = days_i.sec_ticks;
  end

  always_comb begin
    sum = ticks_q.day_ticks + SumWidth'(ticks_q.sec_ticks);
    case (ticks_q.status)
      StatusEarly: tod_d = '0;
      StatusLate:  tod_d = '1;
      default:     tod_d = {sum, {FinalShift{1'b0}}};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else begin
      if (rdy_a) vld_a_q <= valid_i;
      if (rdy_b) vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a && valid_i) ticks_q <= ticks_d;
    if (rdy_b && vld_a_q) begin
      tod_q    <= tod_d;
      status_q <= ticks_q.status;
    end
  end

endmodule

// File: rtl/bcd_calendar_to_tod_clock.sv
// Top level of the BCD calendar to 64-bit time-of-day converter.
// Converts one BCD clock reading per transaction into a count of 1/4096 microsecond
// units since 1900-01-01 00:00:00, with status 0 (valid), 1 (before 1900, count all
// zeros) or 2 (past 2042-09-17 23:53:47, count all ones). The block is a five-stage
// pipeline: BCD decode, range check and day terms, day count with seconds scaling,
// day ticks multiply, and final sum with the output register. A new transaction is
// accepted every cycle while in_stall_o is low; a stall on the output backs up stage
// by stage, so empty stages still fill.
`timescale 1ns / 1ps

module bcd_calendar_to_tod_clock import bcdtod_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  century_bcd_i,
  input  logic [7:0]  year_in_century_bcd_i,
  input  logic [7:0]  month_bcd_i,
  input  logic [7:0]  day_bcd_i,
  input  logic [7:0]  hour_bcd_i,
  input  logic [7:0]  minute_bcd_i,
  input  logic [7:0]  second_bcd_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] tod_high_o,
  output logic [31:0] tod_low_o,
  output logic [1:0]  status_o
);

  logic                dec_ready, dec_valid;
  logic                days_ready, days_valid;
  logic                scale_ready;
  terms_t              terms;
  days_t               days;
  logic [TodWidth-1:0] tod;
  status_e             status;

  assign in_stall_o = !dec_ready;

  bcdtod_decode u_decode (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .valid_i               (in_valid_i),
    .ready_o               (dec_ready),
    .century_bcd_i         (century_bcd_i),
    .year_in_century_bcd_i (year_in_century_bcd_i),
    .month_bcd_i           (month_bcd_i),
    .day_bcd_i             (day_bcd_i),
    .hour_bcd_i            (hour_bcd_i),
    .minute_bcd_i          (minute_bcd_i),
    .second_bcd_i          (second_bcd_i),
    .valid_o               (dec_valid),
    .ready_i               (days_ready),
    .terms_o               (terms)
  );

  bcdtod_days u_days (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (days_ready),
    .terms_i (terms),
    .valid_o (days_valid),
    .ready_i (scale_ready),
    .days_o  (days)
  );

  bcdtod_scale u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (days_valid),
    .ready_o  (scale_ready),
    .days_i   (days),
    .valid_o  (out_valid_o),
    .ready_i  (!out_stall_i),
    .tod_o    (tod),
    .status_o (status)
  );

  assign tod_high_o = tod[63:32];
  assign tod_low_o  = tod[31:0];
  assign status_o   = status;

`ifndef SYNTHESIS
  a_late_all_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StatusLate) |-> (tod_high_o == '1 && tod_low_o == '1))
    else $error("late reading without saturated count");

  a_early_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StatusEarly) |-> (tod_high_o == '0 && tod_low_o == '0))
    else $error("early reading without zero count");

  a_ok_shifted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == StatusOk) |-> (tod_low_o[FinalShift-1:0] == '0))
    else $error("valid count has nonzero low tick bits");

  a_stall_backs_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output side is free");
`endif

endmodule
